@@ rtl/i2c_ram_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: shared package
// Item and result layouts, transaction and segment codes, and the tables that
// give the order and length of the segments of each transaction.
// ----------------------------------------------------------------------------
package i2c_ram_pkg;

    localparam int IDX_W = 4;
    localparam int OFF_W = 5;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

    typedef enum logic [1:0] {
        OP_IDLE      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_READ_BYTE = 2'd2,
        OP_READ_WORD = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        SEG_START     = 4'd0,
        SEG_SEND_AW   = 4'd1,
        SEG_SEND_REG  = 4'd2,
        SEG_SEND_DATA = 4'd3,
        SEG_SEND_AR   = 4'd4,
        SEG_READ      = 4'd5,
        SEG_ACK       = 4'd6,
        SEG_NAK       = 4'd7,
        SEG_STOP      = 4'd8
    } seg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        nack;
    } res_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } eng_status_t;

    function automatic seg_t seg_at(input op_t op, input logic [IDX_W-1:0] idx);
        seg_t s;
        s = SEG_STOP;
        case (idx)
            4'd0: s = SEG_START;
            4'd1: s = SEG_SEND_AW;
            4'd2: s = SEG_SEND_REG;
            4'd3: s = (op == OP_WRITE) ? SEG_SEND_DATA : SEG_START;
            4'd4: s = (op == OP_WRITE) ? SEG_STOP : SEG_SEND_AR;
            4'd5: s = SEG_READ;
            4'd6: s = (op == OP_READ_WORD) ? SEG_ACK : SEG_NAK;
            4'd7: s = (op == OP_READ_WORD) ? SEG_READ : SEG_STOP;
            4'd8: s = SEG_NAK;
            default: s = SEG_STOP;
        endcase
        return s;
    endfunction

    function automatic logic [IDX_W-1:0] seg_last_idx(input op_t op);
        logic [IDX_W-1:0] n;
        case (op)
            OP_WRITE:     n = 4'd4;
            OP_READ_BYTE: n = 4'd7;
            OP_READ_WORD: n = 4'd9;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [OFF_W-1:0] seg_last_off(input seg_t s);
        logic [OFF_W-1:0] n;
        case (s)
            SEG_READ:      n = 5'd16;
            SEG_SEND_AW,
            SEG_SEND_REG,
            SEG_SEND_DATA,
            SEG_SEND_AR:   n = 5'd27;
            default:       n = 5'd3;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/i2c_ram_in_stage.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: input register
// Holds one accepted command or tick until the engine takes it.
// ----------------------------------------------------------------------------
module i2c_ram_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2c_ram_pkg::item_t  in_item,
    input  logic                take,
    output logic                held_valid,
    output i2c_ram_pkg::item_t  held_item
);
    import i2c_ram_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/i2c_ram_engine.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: line sequencer
// Keeps the transaction state and performs one SCL or SDA change per step.
// ----------------------------------------------------------------------------
module i2c_ram_engine
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  i2c_ram_pkg::item_t          item,
    input  logic [6:0]                  dev_addr,
    output i2c_ram_pkg::res_t           res_next,
    output i2c_ram_pkg::eng_status_t    status
);
    import i2c_ram_pkg::*;

    op_t              op_kind_reg,        op_kind_next;
    logic [IDX_W-1:0] seg_idx_reg,        seg_idx_next;
    logic [OFF_W-1:0] seg_off_reg,        seg_off_next;
    logic [1:0]       bit_ph_reg,         bit_ph_next;
    logic [7:0]       held_register_reg,  held_register_next;
    logic [7:0]       held_data_reg,      held_data_next;
    logic [7:0]       shift_byte_reg,     shift_byte_next;
    logic [15:0]      collected_word_reg, collected_word_next;
    logic             clock_level_reg,    clock_level_next;
    logic             data_level_reg,     data_level_next;
    logic             last_ack_reg,       last_ack_next;

    logic             start;
    op_t              op_cur;
    logic [IDX_W-1:0] idx_cur;
    logic [OFF_W-1:0] off_cur;
    seg_t             seg_cur;
    logic             active;
    logic             seg_end;
    logic             txn_end;
    logic [7:0]       send_val;
    logic [7:0]       shift_in;

    assign start   = (op_kind_reg == OP_IDLE) && (op_t'(item.func) != OP_IDLE);
    assign op_cur  = start ? op_t'(item.func) : op_kind_reg;
    assign idx_cur = start ? '0 : seg_idx_reg;
    assign off_cur = start ? '0 : seg_off_reg;
    assign seg_cur = seg_at(op_cur, idx_cur);
    assign active  = (op_cur != OP_IDLE);
    assign seg_end = (off_cur == seg_last_off(seg_cur));
    assign txn_end = active && seg_end && (idx_cur == seg_last_idx(op_cur));

    assign status.op  = op_kind_reg;
    assign status.idx = seg_idx_reg;

    // Sequencing: transaction kind, segment and offset within the segment.
    always_comb
    begin
        op_kind_next = op_cur;
        seg_idx_next = idx_cur;
        seg_off_next = off_cur;
        if (txn_end)
        begin
            op_kind_next = OP_IDLE;
            seg_idx_next = '0;
            seg_off_next = '0;
        end
        else if (active && seg_end)
        begin
            seg_idx_next = idx_cur + 1'b1;
            seg_off_next = '0;
        end
        else if (active)
        begin
            seg_off_next = off_cur + 1'b1;
        end
    end

    // Line changes and data path.
    always_comb
    begin
        held_register_next  = start ? item.reg_addr : held_register_reg;
        held_data_next      = start ? item.wr_data  : held_data_reg;
        collected_word_next = start ? 16'd0 : collected_word_reg;
        shift_byte_next     = shift_byte_reg;
        bit_ph_next         = bit_ph_reg;
        clock_level_next    = clock_level_reg;
        data_level_next     = data_level_reg;
        last_ack_next       = last_ack_reg;
        shift_in            = {shift_byte_reg[6:0], item.sda_in};

        case (seg_cur)
            SEG_SEND_AW:  send_val = {dev_addr, 1'b0};
            SEG_SEND_AR:  send_val = {dev_addr, 1'b1};
            SEG_SEND_REG: send_val = held_register_next;
            default:      send_val = held_data_next;
        endcase

        if (active)
        begin
            case (seg_cur)
                SEG_READ:
                begin
                    if (off_cur == 5'd0)
                    begin
                        clock_level_next = 1'b0;
                        shift_byte_next  = 8'd0;
                    end
                    else if (off_cur[0])
                    begin
                        clock_level_next = 1'b1;
                    end
                    else
                    begin
                        clock_level_next = 1'b0;
                        shift_byte_next  = shift_in;
                        if (off_cur == 5'd16)
                        begin
                            collected_word_next = {collected_word_next[7:0], shift_in};
                        end
                    end
                end
                SEG_SEND_AW, SEG_SEND_REG, SEG_SEND_DATA, SEG_SEND_AR:
                begin
                    if (off_cur == 5'd0)
                    begin
                        clock_level_next = 1'b0;
                        shift_byte_next  = send_val;
                        bit_ph_next      = 2'd0;
                    end
                    else if (off_cur <= 5'd24)
                    begin
                        bit_ph_next = (bit_ph_reg == 2'd2) ? 2'd0 : bit_ph_reg + 2'd1;
                        case (bit_ph_reg)
                            2'd0: data_level_next = shift_byte_reg[7];
                            2'd1: clock_level_next = 1'b1;
                            default:
                            begin
                                clock_level_next = 1'b0;
                                shift_byte_next  = {shift_byte_reg[6:0], 1'b0};
                            end
                        endcase
                    end
                    else if (off_cur == 5'd25)
                    begin
                        data_level_next = 1'b1;
                    end
                    else if (off_cur == 5'd26)
                    begin
                        clock_level_next = 1'b1;
                    end
                    else
                    begin
                        clock_level_next = 1'b0;
                        last_ack_next    = item.sda_in;
                    end
                end
                SEG_START:
                begin
                    case (off_cur[1:0])
                        2'd0:    data_level_next  = 1'b1;
                        2'd1:    clock_level_next = 1'b1;
                        2'd2:    data_level_next  = 1'b0;
                        default: clock_level_next = 1'b0;
                    endcase
                end
                SEG_ACK:
                begin
                    case (off_cur[1:0])
                        2'd0:    data_level_next  = 1'b0;
                        2'd1:    clock_level_next = 1'b1;
                        2'd2:    clock_level_next = 1'b0;
                        default: data_level_next  = 1'b1;
                    endcase
                end
                SEG_NAK:
                begin
                    case (off_cur[1:0])
                        2'd0:    data_level_next  = 1'b1;
                        2'd1:    clock_level_next = 1'b1;
                        2'd2:    clock_level_next = 1'b0;
                        default: data_level_next  = 1'b1;
                    endcase
                end
                default:
                begin
                    case (off_cur[1:0])
                        2'd0:    clock_level_next = 1'b0;
                        2'd1:    data_level_next  = 1'b0;
                        2'd2:    clock_level_next = 1'b1;
                        default: data_level_next  = 1'b1;
                    endcase
                end
            endcase
        end

        res_next.scl        = clock_level_next;
        res_next.sda_out    = data_level_next;
        res_next.busy_res   = active;
        res_next.done_res   = txn_end;
        res_next.read_value = (txn_end && (op_cur != OP_WRITE)) ? collected_word_next : 16'd0;
        res_next.nack       = last_ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_kind_reg        <= OP_IDLE;
            seg_idx_reg        <= '0;
            seg_off_reg        <= '0;
            bit_ph_reg         <= 2'd0;
            held_register_reg  <= 8'd0;
            held_data_reg      <= 8'd0;
            shift_byte_reg     <= 8'd0;
            collected_word_reg <= 16'd0;
            clock_level_reg    <= 1'b1;
            data_level_reg     <= 1'b1;
            last_ack_reg       <= 1'b1;
        end
        else if (step)
        begin
            op_kind_reg        <= op_kind_next;
            seg_idx_reg        <= seg_idx_next;
            seg_off_reg        <= seg_off_next;
            bit_ph_reg         <= bit_ph_next;
            held_register_reg  <= held_register_next;
            held_data_reg      <= held_data_next;
            shift_byte_reg     <= shift_byte_next;
            collected_word_reg <= collected_word_next;
            clock_level_reg    <= clock_level_next;
            data_level_reg     <= data_level_next;
            last_ack_reg       <= last_ack_next;
        end
    end

endmodule

@@ rtl/i2c_register_access_master.sv @@
// Each input transfer is held in the input register and its result in the result register.
// Throughput: one item per cycle while the receiver accepts results, set by the input register and the result
// register, with the sequencer state updated in the same cycle as the result is registered.
// Reset (rst_n low, asynchronous): idle, both lines released, the
// acknowledge flag set and the device address at its default of 104.
// ----------------------------------------------------------------------------
// I2C register access master: top level
// Stream wrapper with input register, line sequencer and result register.
// ----------------------------------------------------------------------------
module i2c_register_access_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_addr[7:0], wr_data[15:8], sda_in[16], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // scl[0], sda_out[1], busy_res[2], read_value[18:3],
                                   // nack[19], zero pad
    output logic        m_tlast,   // done_res
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata  // device_address
);
    import i2c_ram_pkg::*;

    item_t       in_item;
    item_t       held_item;
    logic        held_valid;
    logic        advance;
    res_t        res_next;
    res_t        res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  dev_addr_reg;
    eng_status_t status;

    assign in_item.func     = s_tuser;
    assign in_item.reg_addr = s_tdata[7:0];
    assign in_item.wr_data  = s_tdata[15:8];
    assign in_item.sda_in   = s_tdata[16];

    assign advance = held_valid && (!out_valid_reg || m_tready);

    i2c_ram_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    i2c_ram_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (held_item),
        .dev_addr (dev_addr_reg),
        .res_next (res_next),
        .status   (status)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dev_addr_reg  <= DEV_ADDR_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                dev_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.done_res;
    assign m_tdata  = {4'd0, res_reg.nack, res_reg.read_value, res_reg.busy_res,
                       res_reg.sda_out, res_reg.scl};

`ifndef ASSERT_OFF
    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.done_res |-> res_reg.busy_res)
        else $error("done without busy");

    a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.read_value != 16'd0) |-> res_reg.done_res)
        else $error("read value outside a done result");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.done_res |=> (status.op == OP_IDLE) && (status.idx == '0))
        else $error("sequencer not idle after final stop");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// I2C register access master: stream testbench
// Drives line-change ticks into the master and follows each one with its own
// model of the bit sequencer: register writes, byte reads and word reads, with
// idle ticks, commands ignored while busy, device address changes, random
// gaps on both sides, a long receiver hold-off and a random traffic phase.
// Every result is compared field by field with the predicted line state.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import i2c_ram_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 40;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;

    i2c_register_access_master dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model of the sequencer state.
    logic [6:0]  bus_addr;
    op_t         cur_op;
    logic [7:0]  phase_cnt;
    logic [7:0]  reg_latch;
    logic [7:0]  data_latch;
    logic [7:0]  shifter;
    logic [15:0] word_acc;
    logic        scl_lvl;
    logic        sda_lvl;
    logic        ack_bit;

    res_t        expected_lines[$];

    int          err_count;
    int          items_sent;
    int          done_seen;
    int          writes_run;
    int          byte_reads_run;
    int          word_reads_run;
    int          cfg_writes;
    int          cycle_count;
    int          tx_max_gap;
    int          rx_max_gap;
    bit          hold_off_req;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int plan_length(input op_t op);
        case (op)
            OP_WRITE:     return 5;
            OP_READ_BYTE: return 8;
            default:      return 10;
        endcase
    endfunction

    function automatic seg_t plan_segment(input op_t op, input int idx);
        seg_t s;
        s = SEG_STOP;
        if (idx == 0 || (idx == 3 && op != OP_WRITE))
            s = SEG_START;
        else if (idx == 1)
            s = SEG_SEND_AW;
        else if (idx == 2)
            s = SEG_SEND_REG;
        else if (idx == 3)
            s = SEG_SEND_DATA;
        else if (idx == 4 && op != OP_WRITE)
            s = SEG_SEND_AR;
        else if (idx == 5 || (idx == 7 && op == OP_READ_WORD))
            s = SEG_READ;
        else if (idx == 6 && op == OP_READ_WORD)
            s = SEG_ACK;
        else if ((idx == 6 && op == OP_READ_BYTE) || idx == 8)
            s = SEG_NAK;
        return s;
    endfunction

    function automatic int segment_ticks(input seg_t s);
        case (s)
            SEG_READ:                                              return 17;
            SEG_SEND_AW, SEG_SEND_REG, SEG_SEND_DATA, SEG_SEND_AR: return 28;
            default:                                               return 4;
        endcase
    endfunction

    function automatic void reset_bus_model();
        bus_addr   = DEV_ADDR_RESET;
        cur_op     = OP_IDLE;
        phase_cnt  = '0;
        reg_latch  = '0;
        data_latch = '0;
        shifter    = '0;
        word_acc   = '0;
        scl_lvl    = 1'b1;
        sda_lvl    = 1'b1;
        ack_bit    = 1'b1;
    endfunction

    function automatic void send_bit_tick(input seg_t s, input int off, input logic sda);
        if (off == 0)
        begin
            scl_lvl = 1'b0;
            case (s)
                SEG_SEND_AW:  shifter = {bus_addr, 1'b0};
                SEG_SEND_AR:  shifter = {bus_addr, 1'b1};
                SEG_SEND_REG: shifter = reg_latch;
                default:      shifter = data_latch;
            endcase
        end
        else if (off <= 24)
        begin
            case ((off - 1) % 3)
                0:       sda_lvl = shifter[7];
                1:       scl_lvl = 1'b1;
                default:
                begin
                    scl_lvl = 1'b0;
                    shifter = shifter << 1;
                end
            endcase
        end
        else if (off == 25)
            sda_lvl = 1'b1;
        else if (off == 26)
            scl_lvl = 1'b1;
        else
        begin
            scl_lvl = 1'b0;
            ack_bit = sda;
        end
    endfunction

    function automatic void read_bit_tick(input int off, input logic sda);
        if (off == 0)
        begin
            scl_lvl = 1'b0;
            shifter = '0;
        end
        else if (off % 2 == 1)
            scl_lvl = 1'b1;
        else
        begin
            scl_lvl = 1'b0;
            shifter = {shifter[6:0], sda};
            if (off == 16)
                word_acc = {word_acc[7:0], shifter};
        end
    endfunction

    function automatic void fixed_tick(input seg_t s, input int off);
        logic [3:0] clk_mask;
        logic [3:0] lvl_bits;
        case (s)
            SEG_START:
            begin
                clk_mask = 4'b1010;
                lvl_bits = 4'b0011;
            end
            SEG_ACK:
            begin
                clk_mask = 4'b0110;
                lvl_bits = 4'b1010;
            end
            SEG_NAK:
            begin
                clk_mask = 4'b0110;
                lvl_bits = 4'b1011;
            end
            default:
            begin
                clk_mask = 4'b0101;
                lvl_bits = 4'b1100;
            end
        endcase
        if (clk_mask[off % 4])
            scl_lvl = lvl_bits[off % 4];
        else
            sda_lvl = lvl_bits[off % 4];
    endfunction

    // Advances the sequencer by one tick and returns the line state after it.
    function automatic res_t advance_bus_model(input logic [1:0] func, input logic [7:0] ra,
                                               input logic [7:0] wd, input logic sda);
        res_t r;
        int   pos;
        int   i;
        int   n;
        int   len;
        seg_t s;
        bit   found;
        r = '0;
        if (cur_op == OP_IDLE && func != OP_IDLE)
        begin
            cur_op     = op_t'(func);
            reg_latch  = ra;
            data_latch = wd;
            phase_cnt  = '0;
            word_acc   = '0;
        end
        if (cur_op != OP_IDLE)
        begin
            pos   = phase_cnt;
            n     = plan_length(cur_op);
            found = 1'b0;
            len   = 0;
            s     = SEG_STOP;
            for (i = 0; i < n; i++)
            begin
                s   = plan_segment(cur_op, i);
                len = segment_ticks(s);
                if (pos < len)
                begin
                    found = 1'b1;
                    break;
                end
                pos -= len;
            end
            if (!found)
            begin
                cur_op    = OP_IDLE;
                phase_cnt = '0;
            end
            else
            begin
                r.busy_res = 1'b1;
                if (s == SEG_READ)
                    read_bit_tick(pos, sda);
                else if (s inside {SEG_SEND_AW, SEG_SEND_REG, SEG_SEND_DATA, SEG_SEND_AR})
                    send_bit_tick(s, pos, sda);
                else
                    fixed_tick(s, pos);
                phase_cnt = phase_cnt + 8'd1;
                if (i == n - 1 && pos == len - 1)
                begin
                    r.done_res = 1'b1;
                    if (cur_op != OP_WRITE)
                        r.read_value = word_acc;
                    cur_op    = OP_IDLE;
                    phase_cnt = '0;
                end
            end
        end
        r.scl     = scl_lvl;
        r.sda_out = sda_lvl;
        r.nack    = ack_bit;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] func, input logic [7:0] ra,
                             input logic [7:0] wd, input logic sda);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {7'd0, sda, wd, ra};
        s_tuser  = func;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_lines.push_back(advance_bus_model(func, ra, wd, sda));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [6:0] addr);
        wait_for_drain();
        cfg_we    = 1'b1;
        cfg_wdata = addr;
        @(negedge clk);
        cfg_we    = 1'b0;
        bus_addr  = addr;
        cfg_writes++;
    endtask

    function automatic logic pick_sda(input int mode);
        if (mode == 0)
            return 1'b0;
        if (mode == 1)
            return 1'b1;
        return logic'($urandom_range(0, 1));
    endfunction

    // Noisy transactions offer random commands on the ticks that the master
    // is expected to ignore.
    task automatic run_transaction(input op_t op, input logic [7:0] ra, input logic [7:0] wd,
                                   input int sda_mode, input bit noisy);
        logic [1:0] func;
        case (op)
            OP_WRITE:     writes_run++;
            OP_READ_BYTE: byte_reads_run++;
            default:      word_reads_run++;
        endcase
        send_item(op, ra, wd, pick_sda(sda_mode));
        while (cur_op != OP_IDLE)
        begin
            func = noisy ? 2'($urandom_range(0, 3)) : OP_IDLE;
            send_item(func, 8'($urandom), 8'($urandom), pick_sda(sda_mode));
        end
    endtask

    task automatic test_idle_lines();
        repeat (6)
            send_item(OP_IDLE, 8'($urandom), 8'($urandom), pick_sda(2));
    endtask

    task automatic test_write_register();
        cfg_write(7'h7F);
        run_transaction(OP_WRITE, 8'hFF, 8'h00, 0, 1'b0);
        run_transaction(OP_WRITE, 8'h00, 8'hFF, 1, 1'b0);
        run_transaction(OP_WRITE, 8'hA5, 8'h5A, 2, 1'b1);
    endtask

    task automatic test_read_byte();
        cfg_write(7'h00);
        run_transaction(OP_READ_BYTE, 8'h00, 8'hFF, 1, 1'b0);
        run_transaction(OP_READ_BYTE, 8'hFF, 8'h00, 0, 1'b0);
        run_transaction(OP_READ_BYTE, 8'h3C, 8'hC3, 2, 1'b1);
    endtask

    task automatic test_read_word();
        cfg_write(DEV_ADDR_RESET);
        run_transaction(OP_READ_WORD, 8'hFF, 8'hFF, 1, 1'b0);
        run_transaction(OP_READ_WORD, 8'h00, 8'h00, 0, 1'b0);
        run_transaction(OP_READ_WORD, 8'h81, 8'h18, 2, 1'b1);
    endtask

    // The new address must appear in the read address byte of a transaction
    // that is already past its write address byte.
    task automatic test_address_change();
        byte_reads_run++;
        send_item(OP_READ_BYTE, 8'($urandom), 8'($urandom), 1'b0);
        while (phase_cnt < 8'd40)
            send_item(OP_IDLE, 8'($urandom), 8'($urandom), 1'b0);
        cfg_write(7'h2A);
        while (cur_op != OP_IDLE)
            send_item(OP_IDLE, 8'($urandom), 8'($urandom), pick_sda(2));
    endtask

    task automatic test_back_to_back();
        tx_max_gap = 0;
        rx_max_gap = 0;
        run_transaction(OP_WRITE, 8'($urandom), 8'($urandom), 2, 1'b1);
        run_transaction(OP_READ_WORD, 8'($urandom), 8'($urandom), 2, 1'b1);
        run_transaction(OP_READ_BYTE, 8'($urandom), 8'($urandom), 2, 1'b1);
        tx_max_gap = 12;
        rx_max_gap = 12;
    endtask

    task automatic test_hold_off();
        tx_max_gap   = 0;
        hold_off_req = 1'b1;
        run_transaction(OP_READ_WORD, 8'($urandom), 8'($urandom), 2, 1'b1);
        tx_max_gap   = 12;
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        int start_items;
        int pick;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                cfg_write(7'($urandom));
            else if (pick == 1)
                cfg_write($urandom_range(0, 1) ? 7'h7F : 7'h00);
            else if (pick == 2)
            begin
                tx_max_gap = 12 * $urandom_range(0, 1);
                rx_max_gap = 12 * $urandom_range(0, 1);
            end
            else if (pick == 3)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(OP_IDLE, 8'($urandom), 8'($urandom), pick_sda(2));
            end
            else
                run_transaction(op_t'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                                $urandom_range(0, 5), $urandom_range(0, 2) == 0);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tlast)
                done_seen++;
            if (expected_lines.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected transfer, expected none, actual %0h",
                             $time, m_tdata);
            end
            else
            begin
                want = expected_lines.pop_front();
                check_field("scl", 16'(want.scl), 16'(m_tdata[0]));
                check_field("sda_out", 16'(want.sda_out), 16'(m_tdata[1]));
                check_field("busy", 16'(want.busy_res), 16'(m_tdata[2]));
                check_field("read_value", want.read_value, m_tdata[18:3]);
                check_field("nack", 16'(want.nack), 16'(m_tdata[19]));
                check_field("done", 16'(want.done_res), 16'(m_tlast));
            end
        end
    end

    // The hold-off is counted here so that the sender keeps offering items.
    initial
    begin : result_receiver
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall = $urandom_range(0, rx_max_gap);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_IDLE;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        hold_off_req = 1'b0;
        tx_max_gap   = 12;
        rx_max_gap   = 12;
        err_count      = 0;
        items_sent     = 0;
        done_seen      = 0;
        writes_run     = 0;
        byte_reads_run = 0;
        word_reads_run = 0;
        cfg_writes     = 0;
        reset_bus_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_lines();
        test_write_register();
        test_read_byte();
        test_read_word();
        test_address_change();
        test_back_to_back();
        test_hold_off();
        test_random_traffic();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d ticks: %0d register writes, %0d byte reads, %0d word reads.",
                 items_sent, writes_run, byte_reads_run, word_reads_run);
        $display("Saw %0d completed transactions over %0d device address settings.",
                 done_seen, cfg_writes);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ i2c_register_access_master.f @@
rtl/i2c_ram_pkg.sv
rtl/i2c_ram_in_stage.sv
rtl/i2c_ram_engine.sv
rtl/i2c_register_access_master.sv
dv/testbench.sv
